@@ sv/pdd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pdd_pkg;

	// default parameter values
	localparam int GAIN_FRAC_BITS_DEF = 24;
	localparam int INTEGRAL_WIDTH_DEF = 48;

	// fixed field widths
	localparam int COUNT_W    = 32;
	localparam int ERR_W      = COUNT_W + 1;
	localparam int DIFF_W     = ERR_W + 1;
	localparam int GAIN_W     = 32;
	localparam int LEVEL_W    = 8;
	localparam int CORR_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// request queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// register reset values
	localparam logic [GAIN_W-1:0]  PROP_GAIN_RST    = 32'd167772;
	localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST   = 32'd13422;
	localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST   = 32'd168;
	localparam logic [LEVEL_W-1:0] BASE_SPEED_RST   = 8'd17;
	localparam logic [LEVEL_W-1:0] MIRROR_TOTAL_RST = 8'd30;
	localparam logic [LEVEL_W-1:0] DRIVE_MIN_RST    = 8'd12;
	localparam logic [LEVEL_W-1:0] DRIVE_MAX_RST    = 8'd18;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROP_GAIN    = 3'd0,
		REG_INTEG_GAIN   = 3'd1,
		REG_DERIV_GAIN   = 3'd2,
		REG_BASE_SPEED   = 3'd3,
		REG_MIRROR_TOTAL = 3'd4,
		REG_DRIVE_MIN    = 3'd5,
		REG_DRIVE_MAX    = 3'd6
	} reg_index_t;

	// configuration bundle handed to the back end
	typedef struct packed {
		logic [GAIN_W-1:0]  prop_gain;
		logic [GAIN_W-1:0]  integ_gain;
		logic [GAIN_W-1:0]  deriv_gain;
		logic [LEVEL_W-1:0] base_speed;
		logic [LEVEL_W-1:0] mirror_total;
		logic [LEVEL_W-1:0] drive_min;
		logic [LEVEL_W-1:0] drive_max;
	} cfg_t;

endpackage

`default_nettype wire

@@ sv/pdd_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pdd_front #(
	parameter int INTEGRAL_WIDTH = pdd_pkg::INTEGRAL_WIDTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic signed [pdd_pkg::COUNT_W-1:0]  left_count,
	input  wire logic signed [pdd_pkg::COUNT_W-1:0]  right_count,
	input  wire logic                                q_full,
	output logic                                     q_push,
	output logic signed [pdd_pkg::ERR_W-1:0]         err,
	output logic signed [INTEGRAL_WIDTH-1:0]         integ,
	output logic signed [pdd_pkg::DIFF_W-1:0]        diff
);

	localparam int ERR_W  = pdd_pkg::ERR_W;
	localparam int IW     = INTEGRAL_WIDTH;

	logic signed [IW-1:0]    integ_q;
	logic signed [ERR_W-1:0] last_err_q;
	logic signed [IW:0]      integ_sum;
	logic                    accept;

	// error is the sum of both wheel counts
	assign err = $signed({left_count[pdd_pkg::COUNT_W-1], left_count})
		+ $signed({right_count[pdd_pkg::COUNT_W-1], right_count});

	// saturating integral update
	always_comb begin
		integ_sum = $signed({integ_q[IW-1], integ_q})
			+ $signed({{(IW+1-ERR_W){err[ERR_W-1]}}, err});
		if (integ_sum[IW] != integ_sum[IW-1]) begin
			integ = integ_sum[IW] ? $signed({1'b1, {(IW-1){1'b0}}})
				: $signed({1'b0, {(IW-1){1'b1}}});
		end else begin
			integ = integ_sum[IW-1:0];
		end
	end

	// derivative input against the previous error
	assign diff = $signed({err[ERR_W-1], err})
		- $signed({last_err_q[ERR_W-1], last_err_q});

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign q_push   = accept;

	// controller state advances once per request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q    <= '0;
			last_err_q <= '0;
		end else if (accept) begin
			integ_q    <= integ;
			last_err_q <= err;
		end
	end

endmodule

`default_nettype wire

@@ sv/pdd_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pdd_queue #(
	parameter int WIDTH = pdd_pkg::ERR_W + pdd_pkg::INTEGRAL_WIDTH_DEF + pdd_pkg::DIFF_W
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	output logic                  pop_valid,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      pop_data
);

	localparam int DEPTH = pdd_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full      = (count_q == (PTR_W+1)'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// fill count stays within the depth
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PTR_W+1)'(DEPTH))
		else $error("queue count beyond depth");

	// a lone pop drains exactly one entry
	assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> count_q == $past(count_q) - 1'b1)
		else $error("queue count wrong after pop");

endmodule

`default_nettype wire

@@ sv/pdd_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pdd_back #(
	parameter int GAIN_FRAC_BITS = pdd_pkg::GAIN_FRAC_BITS_DEF,
	parameter int INTEGRAL_WIDTH = pdd_pkg::INTEGRAL_WIDTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire pdd_pkg::cfg_t                      cfg,
	input  wire logic                               q_valid,
	output logic                                    q_pop,
	input  wire logic signed [pdd_pkg::ERR_W-1:0]   err,
	input  wire logic signed [INTEGRAL_WIDTH-1:0]   integ,
	input  wire logic signed [pdd_pkg::DIFF_W-1:0]  diff,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic [pdd_pkg::LEVEL_W-1:0]             first_drive,
	output logic [pdd_pkg::LEVEL_W-1:0]             second_drive,
	output logic signed [pdd_pkg::CORR_W-1:0]       correction_out
);

	localparam int F       = GAIN_FRAC_BITS;
	localparam int IW      = INTEGRAL_WIDTH;
	localparam int GW      = pdd_pkg::GAIN_W + 1;
	localparam int ERR_W   = pdd_pkg::ERR_W;
	localparam int DIFF_W  = pdd_pkg::DIFF_W;
	localparam int LO_W    = 32;
	localparam int IHI_W   = IW - LO_W;
	localparam int PE_W    = GW + ERR_W;
	localparam int PD_W    = GW + DIFF_W;
	localparam int PIL_W   = pdd_pkg::GAIN_W + LO_W;
	localparam int PIH_W   = GW + IHI_W;
	localparam int PI_W    = GW + IW;
	localparam int PED_W   = PD_W + 1;
	localparam int SUM_W   = pdd_pkg::GAIN_W + IW + 4;
	localparam int CORR_W  = pdd_pkg::CORR_W;
	localparam int LEVEL_W = pdd_pkg::LEVEL_W;
	localparam int CALC_W  = CORR_W + 2;

	logic adv;

	logic                     valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic signed [PE_W-1:0]   prod_e_s1;
	logic signed [PD_W-1:0]   prod_d_s1;
	logic [PIL_W-1:0]         prod_il_s1;
	logic signed [PIH_W-1:0]  prod_ih_s1;
	logic signed [PI_W-1:0]   prod_i_s2;
	logic signed [PED_W-1:0]  prod_ed_s2;
	logic signed [SUM_W-1:0]  sum_s3;
	logic signed [CORR_W-1:0] corr_s4;
	logic [LEVEL_W-1:0]       first_s5, second_s5;
	logic signed [CORR_W-1:0] corr_s5;

	logic signed [SUM_W-1:0]  rnd_sum;
	logic signed [SUM_W-1:0]  rnd_shift;
	logic signed [CORR_W-1:0] corr_sat;
	logic signed [CALC_W-1:0] base_x, mirror_x, min_x, max_x, corr_x;
	logic signed [CALC_W-1:0] m1, m2;

	// whole pipeline holds while a result waits at the output
	assign adv   = !(valid_s5 && out_stall);
	assign q_pop = q_valid && adv;

	// stage 1: gain products, integral split in two halves
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_e_s1  <= $signed({1'b0, cfg.prop_gain}) * err;
			prod_d_s1  <= $signed({1'b0, cfg.deriv_gain}) * diff;
			prod_il_s1 <= cfg.integ_gain * integ[LO_W-1:0];
			prod_ih_s1 <= $signed({1'b0, cfg.integ_gain}) * $signed(integ[IW-1:LO_W]);
		end
	end

	// stage 2: rejoin integral product, add the other two
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_i_s2  <= $signed({prod_ih_s1, {LO_W{1'b0}}})
				+ $signed({{(PI_W-PIL_W){1'b0}}, prod_il_s1});
			prod_ed_s2 <= $signed({{(PED_W-PE_W){prod_e_s1[PE_W-1]}}, prod_e_s1})
				+ $signed({{(PED_W-PD_W){prod_d_s1[PD_W-1]}}, prod_d_s1});
		end
	end

	// stage 3: full-precision correction sum
	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s3 <= $signed({{(SUM_W-PI_W){prod_i_s2[PI_W-1]}}, prod_i_s2})
				+ $signed({{(SUM_W-PED_W){prod_ed_s2[PED_W-1]}}, prod_ed_s2});
		end
	end

	// round half away from zero, then saturate to the output width
	always_comb begin
		rnd_sum = sum_s3
			+ $signed({{(SUM_W-F){1'b0}}, 1'b1, {(F-1){1'b0}}})
			- $signed({{(SUM_W-1){1'b0}}, sum_s3[SUM_W-1]});
		rnd_shift = rnd_sum >>> F;
		if (rnd_shift[SUM_W-1:CORR_W-1] == {(SUM_W-CORR_W+1){1'b0}}
			|| rnd_shift[SUM_W-1:CORR_W-1] == {(SUM_W-CORR_W+1){1'b1}}) begin
			corr_sat = rnd_shift[CORR_W-1:0];
		end else if (rnd_shift[SUM_W-1]) begin
			corr_sat = $signed({1'b1, {(CORR_W-1){1'b0}}});
		end else begin
			corr_sat = $signed({1'b0, {(CORR_W-1){1'b1}}});
		end
	end

	// stage 4: rounded correction
	always_ff @(posedge clk) begin
		if (adv) begin
			corr_s4 <= corr_sat;
		end
	end

	// motor levels and their clamps
	always_comb begin
		base_x   = $signed({{(CALC_W-LEVEL_W){1'b0}}, cfg.base_speed});
		mirror_x = $signed({{(CALC_W-LEVEL_W){1'b0}}, cfg.mirror_total});
		min_x    = $signed({{(CALC_W-LEVEL_W){1'b0}}, cfg.drive_min});
		max_x    = $signed({{(CALC_W-LEVEL_W){1'b0}}, cfg.drive_max});
		corr_x   = $signed({{(CALC_W-CORR_W){corr_s4[CORR_W-1]}}, corr_s4});
		m1 = mirror_x - base_x - corr_x;
		m2 = base_x - corr_x;
		// mirrored motor: low bound first
		if (m1 < min_x) begin
			m1 = min_x;
		end
		if (m1 > max_x) begin
			m1 = max_x;
		end
		// direct motor: high bound first
		if (m2 > max_x) begin
			m2 = max_x;
		end
		if (m2 < min_x) begin
			m2 = min_x;
		end
	end

	// stage 5: output register
	always_ff @(posedge clk) begin
		if (adv) begin
			first_s5  <= m1[LEVEL_W-1:0];
			second_s5 <= m2[LEVEL_W-1:0];
			corr_s5   <= corr_s4;
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= q_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	assign out_valid      = valid_s5;
	assign first_drive    = first_s5;
	assign second_drive   = second_s5;
	assign correction_out = corr_s5;

	// a held pipeline keeps its inner requests
	assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> valid_s4 == $past(valid_s4) && valid_s1 == $past(valid_s1))
		else $error("pipeline request lost while held");

	// with sane bounds the direct motor level stays inside them
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 && cfg.drive_min <= cfg.drive_max
		|-> second_s5 >= cfg.drive_min && second_s5 <= cfg.drive_max)
		else $error("direct drive level outside bounds");

endmodule

`default_nettype wire

@@ sv/pid_differential_drive.sv @@
// a request goes through the queue and stages s1 to s5 to the output register
// throughput: one request per cycle unless in_stall; a 4-entry queue decouples
//   front and back, and the whole back pipeline holds while its output is stalled
// reset: arst_n clears integral, last error, queue and pipeline valid bits;
//   configuration registers return to their default gains and levels
`timescale 1ns / 1ps
`default_nettype none

module pid_differential_drive #(
	parameter int GAIN_FRAC_BITS = pdd_pkg::GAIN_FRAC_BITS_DEF,
	parameter int INTEGRAL_WIDTH = pdd_pkg::INTEGRAL_WIDTH_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_write,
	input  wire logic [pdd_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [pdd_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic signed [pdd_pkg::COUNT_W-1:0]   left_count,
	input  wire logic signed [pdd_pkg::COUNT_W-1:0]   right_count,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic [pdd_pkg::LEVEL_W-1:0]               first_drive,
	output logic [pdd_pkg::LEVEL_W-1:0]               second_drive,
	output logic signed [pdd_pkg::CORR_W-1:0]         correction_out
);

	localparam int ERR_W  = pdd_pkg::ERR_W;
	localparam int DIFF_W = pdd_pkg::DIFF_W;
	localparam int IW     = INTEGRAL_WIDTH;
	localparam int QW     = ERR_W + IW + DIFF_W;

	pdd_pkg::cfg_t cfg_q;

	logic                     q_full, q_push, q_valid, q_pop;
	logic signed [ERR_W-1:0]  f_err;
	logic signed [IW-1:0]     f_integ;
	logic signed [DIFF_W-1:0] f_diff;
	logic [QW-1:0]            q_wdata, q_rdata;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain    <= pdd_pkg::PROP_GAIN_RST;
			cfg_q.integ_gain   <= pdd_pkg::INTEG_GAIN_RST;
			cfg_q.deriv_gain   <= pdd_pkg::DERIV_GAIN_RST;
			cfg_q.base_speed   <= pdd_pkg::BASE_SPEED_RST;
			cfg_q.mirror_total <= pdd_pkg::MIRROR_TOTAL_RST;
			cfg_q.drive_min    <= pdd_pkg::DRIVE_MIN_RST;
			cfg_q.drive_max    <= pdd_pkg::DRIVE_MAX_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				pdd_pkg::REG_PROP_GAIN: begin
					cfg_q.prop_gain <= cfg_data[pdd_pkg::GAIN_W-1:0];
				end
				pdd_pkg::REG_INTEG_GAIN: begin
					cfg_q.integ_gain <= cfg_data[pdd_pkg::GAIN_W-1:0];
				end
				pdd_pkg::REG_DERIV_GAIN: begin
					cfg_q.deriv_gain <= cfg_data[pdd_pkg::GAIN_W-1:0];
				end
				pdd_pkg::REG_BASE_SPEED: begin
					cfg_q.base_speed <= cfg_data[pdd_pkg::LEVEL_W-1:0];
				end
				pdd_pkg::REG_MIRROR_TOTAL: begin
					cfg_q.mirror_total <= cfg_data[pdd_pkg::LEVEL_W-1:0];
				end
				pdd_pkg::REG_DRIVE_MIN: begin
					cfg_q.drive_min <= cfg_data[pdd_pkg::LEVEL_W-1:0];
				end
				pdd_pkg::REG_DRIVE_MAX: begin
					cfg_q.drive_max <= cfg_data[pdd_pkg::LEVEL_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// front: error, integral and difference per request
	pdd_front #(
		.INTEGRAL_WIDTH(INTEGRAL_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.left_count (left_count),
		.right_count(right_count),
		.q_full     (q_full),
		.q_push     (q_push),
		.err        (f_err),
		.integ      (f_integ),
		.diff       (f_diff)
	);

	// queue between front and back
	assign q_wdata = {f_err, f_integ, f_diff};

	pdd_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_wdata),
		.full     (q_full),
		.pop_valid(q_valid),
		.pop      (q_pop),
		.pop_data (q_rdata)
	);

	// back: products, rounding and motor clamps
	pdd_back #(
		.GAIN_FRAC_BITS(GAIN_FRAC_BITS),
		.INTEGRAL_WIDTH(INTEGRAL_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_valid       (q_valid),
		.q_pop         (q_pop),
		.err           ($signed(q_rdata[QW-1:IW+DIFF_W])),
		.integ         ($signed(q_rdata[IW+DIFF_W-1:DIFF_W])),
		.diff          ($signed(q_rdata[DIFF_W-1:0])),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.first_drive   (first_drive),
		.second_drive  (second_drive),
		.correction_out(correction_out)
	);

endmodule

`default_nettype wire
